@@ hdl/length_prefixed_packet_ring_top_defines.svh @@
// Assertion macros for the checker file of the packet ring.
`ifndef LENGTH_PREFIXED_PACKET_RING_TOP_DEFINES_SVH
`define LENGTH_PREFIXED_PACKET_RING_TOP_DEFINES_SVH

// Concurrent assertion on a named clock and active-low reset.
`define LPPR_ASSERT_RST(label, clk_sig, rst_sig, prop, msg) \
    label: assert property (@(posedge clk_sig) disable iff (!rst_sig) prop) \
        else $error(msg);

// Concurrent assertion on the block clock clk and reset rst_n.
`define LPPR_ASSERT(label, prop, msg) `LPPR_ASSERT_RST(label, clk, rst_n, prop, msg)

`endif

@@ hdl/lppr_pkg.sv @@
// Types and constants shared by the packet ring modules.
`default_nettype none

package lppr_pkg;

    // Pointer width covers the largest ring size a configuration can describe.
    localparam int PTR_W  = 11;
    localparam int LEN_W  = 7;
    localparam int CNT_W  = 7;
    localparam int BYTE_W = 8;

    // Largest packet length accepted by a start transaction.
    localparam logic [LEN_W-1:0] MAX_PACKET = 7'd64;

    // Configuration register indexes, taken from paddr bit 2.
    localparam logic REG_MAX_PACKETS = 1'b0;
    localparam logic REG_DATA_BYTES  = 1'b1;

    typedef enum logic [1:0] {
        OP_START = 2'd0,
        OP_DATA  = 2'd1,
        OP_DEQ   = 2'd2,
        OP_NONE  = 2'd3
    } opcode_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_FULL    = 2'd1,
        ST_EMPTY   = 2'd2,
        ST_NO_OPEN = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_DQ_LEN,
        S_DQ_RUN
    } state_t;

    // Configuration view handed from the register block to the controller.
    typedef struct packed {
        logic [PTR_W-1:0] ring_size;
        logic [CNT_W-1:0] max_packets;
        logic             ring_fits;
    } cfg_t;

    // One write port and one read port into the ring memory.
    typedef struct packed {
        logic              wr_en;
        logic [PTR_W-1:0]  wr_ptr;
        logic [BYTE_W-1:0] wr_data;
        logic              rd_en;
        logic [PTR_W-1:0]  rd_ptr;
    } mem_req_t;

    // One result transaction.
    typedef struct packed {
        logic [BYTE_W-1:0] out_byte;
        logic              last;
        status_t           status;
        logic [LEN_W-1:0]  returned_length;
        logic [CNT_W-1:0]  packets_held;
        logic              queue_empty;
    } result_t;

endpackage

`default_nettype wire

@@ hdl/lppr_cfg.sv @@
// Configuration registers of the packet ring on an APB-style port.
`default_nettype none

module lppr_cfg #(
    parameter int RING_DEPTH = 1024
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 psel,
    input  wire logic                 penable,
    input  wire logic                 pwrite,
    input  wire logic [2:0]           paddr,
    input  wire logic [31:0]          pwdata,
    output logic      [31:0]          prdata,
    output logic                      pready,
    output lppr_pkg::cfg_t            cfg
);

    logic [lppr_pkg::CNT_W-1:0] max_packets_reg;
    logic [9:0]                 data_bytes_reg;
    logic                       wr_fire;
    logic [lppr_pkg::PTR_W-1:0] ring_size;

    assign pready  = 1'b1;
    assign wr_fire = psel && penable && pwrite;

    // Register writes in the access phase.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_packets_reg <= 7'd16;
            data_bytes_reg  <= 10'd1007;
        end
        else if (wr_fire)
        begin
            if (paddr[2] == lppr_pkg::REG_MAX_PACKETS)
            begin
                max_packets_reg <= pwdata[lppr_pkg::CNT_W-1:0];
            end
            else
            begin
                data_bytes_reg <= pwdata[9:0];
            end
        end
    end

    // Read data follows the address.
    always_comb
    begin
        if (paddr[2] == lppr_pkg::REG_DATA_BYTES)
        begin
            prdata = 32'(data_bytes_reg);
        end
        else
        begin
            prdata = 32'(max_packets_reg);
        end
    end

    // Ring size is payload capacity plus one length byte per packet plus a spare slot.
    assign ring_size = lppr_pkg::PTR_W'(data_bytes_reg)
                     + lppr_pkg::PTR_W'(max_packets_reg)
                     + lppr_pkg::PTR_W'(1);

    assign cfg.ring_size   = ring_size;
    assign cfg.max_packets = max_packets_reg;
    assign cfg.ring_fits   = (32'(ring_size) <= RING_DEPTH);

endmodule

`default_nettype wire

@@ hdl/lppr_mem.sv @@
// Byte ring memory with one write port and one registered read port.
`default_nettype none

module lppr_mem #(
    parameter int RING_DEPTH = 1024
) (
    input  wire logic                        clk,
    input  wire lppr_pkg::mem_req_t          mem_req,
    output logic [lppr_pkg::BYTE_W-1:0]      rd_data
);

    localparam int AW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;

    logic [lppr_pkg::BYTE_W-1:0] ring_mem [RING_DEPTH];
    logic [lppr_pkg::BYTE_W-1:0] rd_data_reg;
    logic [AW-1:0]               wr_idx;
    logic [AW-1:0]               rd_idx;

    // Pointer modulo the memory depth by conditional subtraction of shifted depths.
    function automatic logic [AW-1:0] to_index(input logic [lppr_pkg::PTR_W-1:0] p);
        logic [lppr_pkg::PTR_W-1:0] r;
        r = p;
        for (int k = lppr_pkg::PTR_W - 1; k >= 0; k--)
        begin
            if ((RING_DEPTH << k) < (1 << lppr_pkg::PTR_W))
            begin
                if (32'(r) >= (RING_DEPTH << k))
                begin
                    r = r - lppr_pkg::PTR_W'(RING_DEPTH << k);
                end
            end
        end
        return AW'(r);
    endfunction

    assign wr_idx = to_index(mem_req.wr_ptr);
    assign rd_idx = to_index(mem_req.rd_ptr);

    // Synchronous write and read; read data holds when no read is issued.
    always_ff @(posedge clk)
    begin
        if (mem_req.wr_en)
        begin
            ring_mem[wr_idx] <= mem_req.wr_data;
        end
        if (mem_req.rd_en)
        begin
            rd_data_reg <= ring_mem[rd_idx];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

@@ hdl/lppr_ctrl.sv @@
// Sequencer of the packet ring: pointers, counters and the output register.
`default_nettype none

module lppr_ctrl (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           in_valid,
    output logic                                in_stall,
    input  wire logic [1:0]                     opcode,
    input  wire logic [lppr_pkg::LEN_W-1:0]     packet_length,
    input  wire logic [lppr_pkg::BYTE_W-1:0]    data_byte,
    input  wire logic [lppr_pkg::LEN_W-1:0]     pop_limit,
    input  wire lppr_pkg::cfg_t                 cfg,
    output lppr_pkg::mem_req_t                  mem_req,
    input  wire logic [lppr_pkg::BYTE_W-1:0]    rd_data,
    output logic                                out_valid,
    input  wire logic                           out_stall,
    output lppr_pkg::result_t                   result
);

    localparam int PW   = lppr_pkg::PTR_W;
    localparam int LW   = lppr_pkg::LEN_W;
    localparam int CW   = lppr_pkg::CNT_W;
    localparam int BW   = lppr_pkg::BYTE_W;
    localparam int SP_W = PW + 2;

    localparam logic signed [SP_W-1:0] SP_ONE = 1;

    lppr_pkg::state_t   state_reg, state_next;
    lppr_pkg::opcode_t  op_reg;
    logic [LW-1:0]      len_reg;
    logic [BW-1:0]      byte_reg;
    logic [LW-1:0]      limit_reg;

    logic [PW-1:0]      head_reg, head_next;
    logic [PW-1:0]      tail_reg, tail_next;
    logic [PW-1:0]      wp_reg, wp_next;
    logic [CW-1:0]      count_reg, count_next;
    logic [LW-1:0]      rem_reg, rem_next;
    logic               open_reg, open_next;

    logic [PW-1:0]      bptr_reg, bptr_next;
    logic [PW-1:0]      eptr_reg, eptr_next;
    logic [BW-1:0]      walk_reg, walk_next;
    logic [LW-1:0]      n_reg, n_next;
    logic [LW-1:0]      issued_reg, issued_next;
    logic               pend_reg, pend_next;
    logic               pend_last_reg, pend_last_next;

    lppr_pkg::result_t  out_reg, out_next;
    logic               out_valid_reg;
    logic               out_load;

    logic               out_free;
    logic               step_done;
    logic               take_item;
    logic               walk_done;
    logic               emit_fire;
    logic               can_issue;
    logic               reject;
    logic               publish;

    logic [PW-1:0]      head_adv, tail_adv, wp_adv, bptr_adv, eptr_adv;
    logic [CW-1:0]      count_inc, count_dec;
    logic [LW-1:0]      rem_dec;
    logic [LW-1:0]      issued_inc;
    logic [BW-1:0]      lim_ext, m_len;
    logic [LW-1:0]      n_calc;
    logic signed [SP_W-1:0] ring_d, space, need;

    // Step a ring pointer, wrapping to zero at or past the ring size.
    function automatic logic [PW-1:0] advance(input logic [PW-1:0] p,
                                              input logic [PW-1:0] s);
        logic [PW:0] n;
        n = {1'b0, p} + (PW + 1)'(1);
        return (n >= {1'b0, s}) ? '0 : n[PW-1:0];
    endfunction

    // Shared arithmetic on the current state.
    assign head_adv   = advance(head_reg, cfg.ring_size);
    assign tail_adv   = advance(tail_reg, cfg.ring_size);
    assign wp_adv     = advance(wp_reg, cfg.ring_size);
    assign bptr_adv   = advance(bptr_reg, cfg.ring_size);
    assign eptr_adv   = advance(eptr_reg, cfg.ring_size);
    assign count_inc  = (count_reg != '1) ? count_reg + CW'(1) : count_reg;
    assign count_dec  = (count_reg != '0) ? count_reg - CW'(1) : count_reg;
    assign rem_dec    = (rem_reg != '0) ? rem_reg - LW'(1) : rem_reg;
    assign issued_inc = issued_reg + LW'(1);

    // Free space check for a start transaction.
    assign ring_d = $signed(SP_W'(head_reg)) - $signed(SP_W'(tail_reg));
    assign space  = (ring_d >= 0) ? ($signed(SP_W'(cfg.ring_size)) - ring_d - SP_ONE)
                                  : (-SP_ONE - ring_d);
    assign need   = $signed(SP_W'(len_reg)) + SP_ONE;
    assign reject = (count_reg >= cfg.max_packets) || (len_reg > lppr_pkg::MAX_PACKET)
                 || !cfg.ring_fits || (need > space);

    // Bytes handed out: the smaller of limit and stored length, capped at the packet maximum.
    assign lim_ext = BW'(limit_reg);
    assign m_len   = (lim_ext < rd_data) ? lim_ext : rd_data;
    assign n_calc  = (m_len > BW'(lppr_pkg::MAX_PACKET)) ? lppr_pkg::MAX_PACKET : m_len[LW-1:0];

    // Dequeue walk and byte issue conditions.
    assign out_free  = !out_valid_reg || !out_stall;
    assign walk_done = (walk_reg == '0);
    assign emit_fire = (state_reg == lppr_pkg::S_DQ_RUN) && pend_reg && walk_done && out_free;
    assign can_issue = (state_reg == lppr_pkg::S_DQ_RUN) && (issued_reg != n_reg)
                    && (!pend_reg || emit_fire);

    assign take_item = in_valid && step_done;
    assign in_stall  = !step_done;

    // Next state, state updates and result formation.
    always_comb
    begin
        state_next     = state_reg;
        head_next      = head_reg;
        tail_next      = tail_reg;
        wp_next        = wp_reg;
        count_next     = count_reg;
        rem_next       = rem_reg;
        open_next      = open_reg;
        bptr_next      = bptr_reg;
        eptr_next      = eptr_reg;
        walk_next      = walk_reg;
        n_next         = n_reg;
        issued_next    = issued_reg;
        pend_next      = pend_reg;
        pend_last_next = pend_last_reg;
        mem_req        = '0;
        out_load       = 1'b0;
        step_done      = 1'b0;
        publish        = 1'b0;
        out_next       = '{out_byte: '0, last: 1'b1, status: lppr_pkg::ST_OK,
                           returned_length: '0, packets_held: count_reg,
                           queue_empty: (head_reg == tail_reg)};

        case (state_reg)
            lppr_pkg::S_IDLE:
            begin
                step_done = 1'b1;
            end

            lppr_pkg::S_EXEC:
            begin
                case (op_reg)
                    lppr_pkg::OP_START:
                    begin
                        if (out_free)
                        begin
                            step_done = 1'b1;
                            out_load  = 1'b1;
                            if (reject)
                            begin
                                out_next.status = lppr_pkg::ST_FULL;
                            end
                            else
                            begin
                                mem_req.wr_en   = 1'b1;
                                mem_req.wr_ptr  = head_reg;
                                mem_req.wr_data = BW'(len_reg);
                                publish         = (len_reg == '0);
                                if (publish)
                                begin
                                    head_next  = head_adv;
                                    wp_next    = head_adv;
                                    count_next = count_inc;
                                    open_next  = 1'b0;
                                    rem_next   = '0;
                                end
                                else
                                begin
                                    wp_next   = head_adv;
                                    rem_next  = len_reg;
                                    open_next = 1'b1;
                                end
                                out_next.packets_held = publish ? count_inc : count_reg;
                                out_next.queue_empty  = publish ? (head_adv == tail_reg)
                                                                : (head_reg == tail_reg);
                            end
                        end
                    end

                    lppr_pkg::OP_DATA:
                    begin
                        if (out_free)
                        begin
                            step_done = 1'b1;
                            out_load  = 1'b1;
                            if (!open_reg)
                            begin
                                out_next.status = lppr_pkg::ST_NO_OPEN;
                            end
                            else
                            begin
                                mem_req.wr_en   = 1'b1;
                                mem_req.wr_ptr  = wp_reg;
                                mem_req.wr_data = byte_reg;
                                wp_next         = wp_adv;
                                publish         = (rem_dec == '0);
                                if (publish)
                                begin
                                    head_next  = wp_adv;
                                    count_next = count_inc;
                                    open_next  = 1'b0;
                                    rem_next   = '0;
                                end
                                else
                                begin
                                    rem_next = rem_dec;
                                end
                                out_next.packets_held = publish ? count_inc : count_reg;
                                out_next.queue_empty  = publish ? (wp_adv == tail_reg)
                                                                : (head_reg == tail_reg);
                            end
                        end
                    end

                    lppr_pkg::OP_DEQ:
                    begin
                        if (head_reg == tail_reg)
                        begin
                            if (out_free)
                            begin
                                step_done       = 1'b1;
                                out_load        = 1'b1;
                                out_next.status = lppr_pkg::ST_EMPTY;
                            end
                        end
                        else
                        begin
                            // Fetch the length byte of the oldest packet.
                            mem_req.rd_en  = 1'b1;
                            mem_req.rd_ptr = tail_reg;
                            state_next     = lppr_pkg::S_DQ_LEN;
                        end
                    end

                    lppr_pkg::OP_NONE:
                    begin
                        step_done = 1'b1;
                    end

                    default:
                    begin
                        step_done = 1'b1;
                    end
                endcase
            end

            lppr_pkg::S_DQ_LEN:
            begin
                // Length byte is on the read port; set up the byte and walk pointers.
                bptr_next      = tail_adv;
                eptr_next      = tail_adv;
                walk_next      = rd_data;
                n_next         = n_calc;
                issued_next    = '0;
                pend_next      = 1'b0;
                pend_last_next = 1'b0;
                count_next     = count_dec;
                state_next     = lppr_pkg::S_DQ_RUN;
            end

            lppr_pkg::S_DQ_RUN:
            begin
                // Walk pointer steps over every stored byte to find the next packet.
                if (!walk_done)
                begin
                    eptr_next = eptr_adv;
                    walk_next = walk_reg - BW'(1);
                end

                // Byte reads run one ahead of the output register.
                if (can_issue)
                begin
                    mem_req.rd_en  = 1'b1;
                    mem_req.rd_ptr = bptr_reg;
                    bptr_next      = bptr_adv;
                    issued_next    = issued_inc;
                    pend_next      = 1'b1;
                    pend_last_next = (issued_inc == n_reg);
                end
                else if (emit_fire)
                begin
                    pend_next = 1'b0;
                end

                out_next.returned_length = n_reg;
                out_next.queue_empty     = (head_reg == eptr_reg);

                if (emit_fire)
                begin
                    out_load          = 1'b1;
                    out_next.out_byte = rd_data;
                    out_next.last     = pend_last_reg;
                    if (pend_last_reg)
                    begin
                        step_done = 1'b1;
                        tail_next = eptr_reg;
                    end
                end
                else if ((n_reg == '0) && walk_done && out_free)
                begin
                    // Zero-length packet or zero limit gives one status-only result.
                    out_load  = 1'b1;
                    step_done = 1'b1;
                    tail_next = eptr_reg;
                end
            end

            default:
            begin
                state_next = lppr_pkg::S_IDLE;
            end
        endcase

        if (take_item)
        begin
            state_next = lppr_pkg::S_EXEC;
        end
        else if (step_done)
        begin
            state_next = lppr_pkg::S_IDLE;
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= lppr_pkg::S_IDLE;
            head_reg      <= '0;
            tail_reg      <= '0;
            wp_reg        <= '0;
            count_reg     <= '0;
            rem_reg       <= '0;
            open_reg      <= 1'b0;
            bptr_reg      <= '0;
            eptr_reg      <= '0;
            walk_reg      <= '0;
            n_reg         <= '0;
            issued_reg    <= '0;
            pend_reg      <= 1'b0;
            pend_last_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            wp_reg        <= wp_next;
            count_reg     <= count_next;
            rem_reg       <= rem_next;
            open_reg      <= open_next;
            bptr_reg      <= bptr_next;
            eptr_reg      <= eptr_next;
            walk_reg      <= walk_next;
            n_reg         <= n_next;
            issued_reg    <= issued_next;
            pend_reg      <= pend_next;
            pend_last_reg <= pend_last_next;
            out_valid_reg <= out_load || (out_valid_reg && out_stall);
        end
    end

    // Captured input transaction and output payload.
    always_ff @(posedge clk)
    begin
        if (take_item)
        begin
            op_reg    <= lppr_pkg::opcode_t'(opcode);
            len_reg   <= packet_length;
            byte_reg  <= data_byte;
            limit_reg <= pop_limit;
        end
        if (out_load)
        begin
            out_reg <= out_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign result    = out_reg;

endmodule

`default_nettype wire

@@ hdl/length_prefixed_packet_ring_top.sv @@
// Top level of the length-prefixed packet ring.
//
//  Channel  Direction  Handshake          Payload
//  in       input      in_valid/in_stall  opcode, packet_length, data_byte, pop_limit
//  out      output     out_valid/out_stall out_byte, last, status, returned_length,
//                                          packets_held, queue_empty
//  cfg      input      APB psel/penable   paddr, pwdata, prdata
//
// Start, data byte and status transactions execute in the EXEC state after acceptance and
// overlap with the next acceptance, so data bytes run at one per cycle while out is not stalled.
// A dequeue reads the length byte, walks over the stored bytes, then gives one byte per cycle
// from the single read port while out is not stalled, or one status-only result for none.
// Reset clears pointers and counters at once; ring memory is not cleared.
// A stalled result holds in the output register while the next item is accepted.
`default_nettype none

module length_prefixed_packet_ring_top #(
    parameter int RING_DEPTH = 1024
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [1:0]  opcode,
    input  wire logic [6:0]  packet_length,
    input  wire logic [7:0]  data_byte,
    input  wire logic [6:0]  pop_limit,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [7:0]       out_byte,
    output logic             last,
    output logic [1:0]       status,
    output logic [6:0]       returned_length,
    output logic [6:0]       packets_held,
    output logic             queue_empty,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    lppr_pkg::cfg_t     cfg;
    lppr_pkg::mem_req_t mem_req;
    lppr_pkg::result_t  result;
    logic [7:0]         rd_data;

    lppr_cfg #(
        .RING_DEPTH (RING_DEPTH)
    ) u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    lppr_mem #(
        .RING_DEPTH (RING_DEPTH)
    ) u_mem (
        .clk     (clk),
        .mem_req (mem_req),
        .rd_data (rd_data)
    );

    lppr_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .opcode        (opcode),
        .packet_length (packet_length),
        .data_byte     (data_byte),
        .pop_limit     (pop_limit),
        .cfg           (cfg),
        .mem_req       (mem_req),
        .rd_data       (rd_data),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .result        (result)
    );

    // Result fields onto their ports.
    assign out_byte        = result.out_byte;
    assign last            = result.last;
    assign status          = result.status;
    assign returned_length = result.returned_length;
    assign packets_held    = result.packets_held;
    assign queue_empty     = result.queue_empty;

endmodule

`default_nettype wire

@@ hdl/lppr_chk.sv @@
// Port checker for the packet ring and its bind to the top level.
`default_nettype none

`include "length_prefixed_packet_ring_top_defines.svh"

module lppr_chk (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       out_valid,
    input wire logic       out_stall,
    input wire logic [7:0] out_byte,
    input wire logic       last,
    input wire logic [1:0] status,
    input wire logic [6:0] returned_length,
    input wire logic       queue_empty
);

    // A result stays offered until taken.
    `LPPR_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid, "result dropped while stalled")

    // A stalled result keeps its payload.
    `LPPR_ASSERT(a_out_stable, out_valid && out_stall |=> $stable(out_byte) && $stable(last) && $stable(status) && $stable(returned_length), "stalled result changed")

    // Any status other than ok is a single status-only transaction.
    `LPPR_ASSERT(a_status_only, out_valid && (status != lppr_pkg::ST_OK) |-> last && (out_byte == 8'd0) && (returned_length == 7'd0), "bad status transaction")

    // An empty dequeue reports an empty queue.
    `LPPR_ASSERT(a_empty_flag, out_valid && (status == lppr_pkg::ST_EMPTY) |-> queue_empty, "empty status without empty queue")

    // Only byte transactions of a dequeue come without the last mark.
    `LPPR_ASSERT(a_mid_byte, out_valid && !last |-> (returned_length != 7'd0) && (status == lppr_pkg::ST_OK), "non-final transaction outside a dequeue")

endmodule

bind length_prefixed_packet_ring_top lppr_chk u_lppr_chk (
    .clk             (clk),
    .rst_n           (rst_n),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_byte        (out_byte),
    .last            (last),
    .status          (status),
    .returned_length (returned_length),
    .queue_empty     (queue_empty)
);

`default_nettype wire
